// ===== rtl/core/cwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_pkg
// Shared types and codes for the common word text decompressor.
// ----------------------------------------------------------------------------
package cwd_pkg;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEXT   = 2'd2
  } req_e;

  // Fault codes carried on the last word of an item
  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_INDEX = 2'd1,
    FAULT_TRUNC = 2'd2,
    FAULT_FULL  = 2'd3
  } fault_e;

  // Kind of the previous element in the current message
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_PLAIN = 2'd2
  } kind_e;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOOKUP = 6'b000010,
    ST_SPACE  = 6'b000100,
    ST_READ   = 6'b001000,
    ST_CHAR   = 6'b010000,
    ST_SINGLE = 6'b100000
  } state_e;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       message_end;
    fault_e     fault;
  } rsp_t;

  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam int         MAX_RESULTS = 32;
  localparam int         NW          = $clog2(MAX_RESULTS + 1);

endpackage

// ===== rtl/core/cwd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_if
// Valid/ready channels for requests and decompressed result words.
// ----------------------------------------------------------------------------
interface cwd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface cwd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       message_end;
  logic [1:0] fault;

  modport source (output valid, out_byte, last, message_end, fault, input ready);
  modport sink   (input valid, out_byte, last, message_end, fault, output ready);
endinterface

// ===== rtl/core/common_word_text_decompressor_unit.sv =====
`timescale 1ns / 1ps
// Path: a plain byte, end marker or fault is registered in the sequencer and
//   then in the output stage (a plain byte after a word first gives a space);
//   a word token passes table read, optional space and dictionary read, then
//   gives one character per cycle while the output stage is free.
// Items: one at a time; a new request is taken only when the last one is done.
// Reset: dictionary counters and message state clear at once; no memory clearing pass.
// ----------------------------------------------------------------------------
// common_word_text_decompressor_unit
// Dictionary loader and text expander built around two synchronous memories.
// ----------------------------------------------------------------------------
module common_word_text_decompressor_unit import cwd_pkg::*; #(
  parameter int DICT_BYTES   = 1024,
  parameter int MAX_WORDS    = 128,
  parameter int MAX_WORD_LEN = 31
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  cwd_req_if.sink   req_i,
  cwd_rsp_if.source rsp_o
);

  localparam int AW  = $clog2(DICT_BYTES);
  localparam int FPW = $clog2(DICT_BYTES + 1);
  localparam int WIW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WCW = $clog2(MAX_WORDS + 1);
  localparam int LW  = $clog2(MAX_WORD_LEN + 1);

  state_e         state_q, state_d;
  logic [FPW-1:0] fill_q, fill_d;
  logic [WCW-1:0] wc_q, wc_d;
  logic           nsw_q, nsw_d;
  kind_e          prev_q, prev_d;

  logic [FPW-1:0] p_q, p_d;
  logic [NW-1:0]  n_q, n_d;
  logic [LW-1:0]  len_q, len_d;
  logic           space_q, space_d;
  logic           word_mode_q, word_mode_d;
  rsp_t           pend_q, pend_d;

  logic [7:0]     dict_mem [DICT_BYTES];
  logic [AW-1:0]  tbl_mem  [MAX_WORDS];
  logic [7:0]     dict_rdata_q;
  logic [AW-1:0]  tbl_rdata_q;
  logic           dict_we, dict_re, tbl_we, tbl_re;
  logic [AW-1:0]  dict_raddr;
  logic [WIW-1:0] tbl_raddr;

  logic           in_fire, out_free, load;
  rsp_t           load_data;
  logic [7:0]     b;
  logic           idx_ok, char_last;
  logic [FPW-1:0] p_inc;
  logic [NW-1:0]  n_inc;
  logic [LW-1:0]  len_inc;

  assign b         = req_i.data_byte;
  assign in_fire   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign idx_ok    = 32'(b[6:0]) < 32'(wc_q);
  assign tbl_raddr = WIW'(b[6:0]);

  // Stop a word at its end mark, the fill point, the length cap or result cap
  assign p_inc     = p_q + FPW'(1);
  assign n_inc     = n_q + NW'(1);
  assign len_inc   = len_q + LW'(1);
  assign char_last = dict_rdata_q[7] || (p_inc >= fill_q) ||
                     (len_inc >= LW'(MAX_WORD_LEN)) || (n_inc >= NW'(MAX_RESULTS));

  // Sequence requests and word expansion
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    wc_d        = wc_q;
    nsw_d       = nsw_q;
    prev_d      = prev_q;
    p_d         = p_q;
    n_d         = n_q;
    len_d       = len_q;
    space_d     = space_q;
    word_mode_d = word_mode_q;
    pend_d      = pend_q;
    dict_we     = 1'b0;
    dict_re     = 1'b0;
    dict_raddr  = p_q[AW-1:0];
    tbl_we      = 1'b0;
    tbl_re      = 1'b0;
    load        = 1'b0;
    load_data   = '{out_byte: 8'h00, last: 1'b1, message_end: 1'b0, fault: FAULT_NONE};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (req_e'(req_i.req_type))
            REQ_CLEAR: begin
              fill_d = '0;
              wc_d   = '0;
              nsw_d  = 1'b1;
              prev_d = KIND_START;
            end
            REQ_APPEND: begin
              if (fill_q >= FPW'(DICT_BYTES) || (nsw_q && wc_q >= WCW'(MAX_WORDS))) begin
                pend_d  = '{out_byte: 8'h00, last: 1'b1, message_end: 1'b0,
                            fault: FAULT_FULL};
                state_d = ST_SINGLE;
              end else begin
                if (nsw_q) begin
                  tbl_we = 1'b1;
                  wc_d   = wc_q + WCW'(1);
                end
                dict_we = 1'b1;
                fill_d  = fill_q + FPW'(1);
                nsw_d   = b[7];
              end
            end
            REQ_TEXT: begin
              if (b == 8'h00) begin
                pend_d  = '{out_byte: 8'h00, last: 1'b1, message_end: 1'b1,
                            fault: FAULT_NONE};
                prev_d  = KIND_START;
                state_d = ST_SINGLE;
              end else if (b[7]) begin
                if (!idx_ok) begin
                  pend_d  = '{out_byte: 8'h00, last: 1'b1, message_end: 1'b0,
                              fault: FAULT_INDEX};
                  state_d = ST_SINGLE;
                end else begin
                  tbl_re      = 1'b1;
                  space_d     = (prev_q != KIND_START);
                  word_mode_d = 1'b1;
                  prev_d      = KIND_WORD;
                  state_d     = ST_LOOKUP;
                end
              end else begin
                pend_d      = '{out_byte: b, last: 1'b1, message_end: 1'b0,
                                fault: FAULT_NONE};
                word_mode_d = 1'b0;
                prev_d      = KIND_PLAIN;
                state_d     = (prev_q == KIND_WORD) ? ST_SPACE : ST_SINGLE;
              end
            end
            default: begin
              // drop unknown request codes
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        p_d     = FPW'(tbl_rdata_q);
        n_d     = '0;
        len_d   = '0;
        state_d = space_q ? ST_SPACE : ST_READ;
      end
      ST_SPACE: begin
        if (out_free) begin
          load      = 1'b1;
          load_data = '{out_byte: SPACE_CHAR, last: 1'b0, message_end: 1'b0,
                        fault: FAULT_NONE};
          n_d       = NW'(1);
          state_d   = word_mode_q ? ST_READ : ST_SINGLE;
        end
      end
      ST_READ: begin
        dict_re = 1'b1;
        state_d = ST_CHAR;
      end
      ST_CHAR: begin
        // Emit the fetched character and fetch the next one in the same cycle
        if (out_free) begin
          load      = 1'b1;
          load_data = '{out_byte: {1'b0, dict_rdata_q[6:0]}, last: char_last,
                        message_end: 1'b0,
                        fault: (char_last && !dict_rdata_q[7]) ? FAULT_TRUNC : FAULT_NONE};
          if (char_last) begin
            state_d = ST_IDLE;
          end else begin
            dict_re    = 1'b1;
            dict_raddr = p_inc[AW-1:0];
            p_d        = p_inc;
            n_d        = n_inc;
            len_d      = len_inc;
          end
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          load      = 1'b1;
          load_data = pend_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      wc_q    <= '0;
      nsw_q   <= 1'b1;
      prev_q  <= KIND_START;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      wc_q    <= wc_d;
      nsw_q   <= nsw_d;
      prev_q  <= prev_d;
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    n_q         <= n_d;
    len_q       <= len_d;
    space_q     <= space_d;
    word_mode_q <= word_mode_d;
    pend_q      <= pend_d;
  end

  // Dictionary byte memory
  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      dict_mem[fill_q[AW-1:0]] <= b;
    end
    if (dict_re) begin
      dict_rdata_q <= dict_mem[dict_raddr];
    end
  end

  // Word start address memory
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[wc_q[WIW-1:0]] <= fill_q[AW-1:0];
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  cwd_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .data_i (load_data),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

`ifndef SYNTHESIS
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free) else $error("result word loaded over a held word");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= FPW'(DICT_BYTES)) && (wc_q <= WCW'(MAX_WORDS)))
    else $error("dictionary counters out of range");

  a_char_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHAR) |-> (n_q < NW'(MAX_RESULTS)))
    else $error("word expansion exceeded the result limit");

  a_word_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req_i.req_type == REQ_TEXT && b[7] && idx_ok) |=>
      (state_q == ST_LOOKUP && prev_q == KIND_WORD))
    else $error("valid word token did not start a lookup");
`endif

endmodule

// ===== rtl/core/cwd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwd_out_stage
// Output register that holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module cwd_out_stage import cwd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  rsp_t      data_i,
  output logic      free_o,
  cwd_rsp_if.source rsp_o
);

  logic valid_q, valid_d;
  rsp_t data_q;

  // Accept a new word when empty or when the held one leaves now
  assign free_o = !valid_q || rsp_o.ready;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload; load only on an accepted slot
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.out_byte    = data_q.out_byte;
  assign rsp_o.last        = data_q.last;
  assign rsp_o.message_end = data_q.message_end;
  assign rsp_o.fault       = data_q.fault;

endmodule
